// ===== src/mdmc_pkg.sv =====
package mdmc_pkg;

  localparam int LEVEL_INDEX_BITS = 12;
  localparam int ADDRESS_BITS     = 32;
  localparam int NUM_LEVELS       = 3;
  localparam int LINE_COUNT       = 2 ** LEVEL_INDEX_BITS;
  // smallest line offset is two bits, so a tag never needs more than this
  localparam int TAG_W            = ADDRESS_BITS - 2;
  localparam int IW_W             = $clog2(LEVEL_INDEX_BITS + 1);
  localparam int SH_W             = $clog2(LEVEL_INDEX_BITS + 7);
  localparam int CFG_IDX_W        = 3;
  localparam int CFG_DATA_W       = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FILTER = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LEVELS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_L1_IW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_L2_IW  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_L3_IW  = 3'd5;

  localparam logic [1:0] FILT_UNIFIED = 2'd0;
  localparam logic [1:0] FILT_INSTR   = 2'd1;
  localparam logic [1:0] FILT_DATA    = 2'd2;

  typedef logic [LEVEL_INDEX_BITS-1:0] idx_t;
  typedef logic [TAG_W-1:0]            tag_t;
  typedef logic [ADDRESS_BITS-1:0]     addr_t;
  typedef logic [IW_W-1:0]             iw_t;

  typedef struct packed {
    logic valid;
    logic dirty;
    tag_t tag;
  } entry_t;

  typedef struct packed {
    idx_t idx;
    tag_t tag;
  } split_t;

  typedef struct packed {
    logic rd_en;
    logic upd_en;
    logic clr_en;
    logic is_write;
  } lvl_ctl_t;

  typedef struct packed {
    logic hit;
    logic victim_dirty;
  } lvl_sts_t;

  function automatic iw_t clamp_iw(input logic [CFG_DATA_W-1:0] w);
    if (int'(w) > LEVEL_INDEX_BITS) begin
      return IW_W'(LEVEL_INDEX_BITS);
    end
    return IW_W'(w);
  endfunction

  function automatic split_t split_addr(input addr_t addr, input logic [2:0] off,
                                        input iw_t iw);
    addr_t           sh_idx;
    addr_t           sh_tag;
    logic [SH_W-1:0] total;
    idx_t            mask;
    split_t          res;
    sh_idx  = addr >> off;
    mask    = ~({LEVEL_INDEX_BITS{1'b1}} << iw);
    total   = SH_W'(off) + SH_W'(iw);
    sh_tag  = addr >> total;
    res.idx = sh_idx[LEVEL_INDEX_BITS-1:0] & mask;
    res.tag = sh_tag[TAG_W-1:0];
    return res;
  endfunction

endpackage

// ===== src/mdmc_if.sv =====
interface mdmc_in_if;
  import mdmc_pkg::*;
  logic  valid;
  logic  ready;
  logic  op;
  logic  is_data;
  addr_t address;
  modport source (output valid, output op, output is_data, output address, input ready);
  modport sink (input valid, input op, input is_data, input address, output ready);
endinterface

interface mdmc_out_if;
  logic       valid;
  logic       ready;
  logic       ignored;
  logic [1:0] hit_level;
  logic [2:0] dirty_evict_mask;
  logic       was_write;
  modport source (output valid, output ignored, output hit_level, output dirty_evict_mask,
                  output was_write, input ready);
  modport sink (input valid, input ignored, input hit_level, input dirty_evict_mask,
                input was_write, output ready);
endinterface

// ===== src/mdmc_level.sv =====
module mdmc_level (
  input  logic              clk,
  input  mdmc_pkg::lvl_ctl_t ctl,
  input  mdmc_pkg::idx_t    rd_idx,
  input  mdmc_pkg::idx_t    wr_idx,
  input  mdmc_pkg::tag_t    cmp_tag,
  output mdmc_pkg::lvl_sts_t sts
);
  import mdmc_pkg::*;

  entry_t mem [LINE_COUNT];
  entry_t rd_q_r;
  entry_t wr_data;
  logic   hit;

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_q_r <= mem[rd_idx];
    end
    if (ctl.clr_en || ctl.upd_en) begin
      mem[wr_idx] <= wr_data;
    end
  end

  assign hit = rd_q_r.valid && (rd_q_r.tag == cmp_tag);

  always_comb begin
    if (ctl.clr_en) begin
      wr_data = '0;
    end else if (hit) begin
      wr_data = '{valid: 1'b1, dirty: rd_q_r.dirty | ctl.is_write, tag: rd_q_r.tag};
    end else begin
      // allocate on miss, dirty only for a write
      wr_data = '{valid: 1'b1, dirty: ctl.is_write, tag: cmp_tag};
    end
  end

  assign sts.hit          = hit;
  assign sts.victim_dirty = rd_q_r.valid && rd_q_r.dirty && !hit;

endmodule

// ===== src/multilevel_direct_mapped_cache_tags.sv =====
// channel   dir  handshake         word
// in_if     in   valid/ready       op, is_data, address
// out_if    out  valid/ready       ignored, hit_level, dirty_evict_mask, was_write
// cfg_*     in   cfg_we only       cfg_index selects register, cfg_data value
//
// all three line memories are read in the accept cycle, and the compare stage then
// compares tags and writes back once the output register can take its result
// one access in the compare stage; a waiting result in the output register holds it there
// after reset a clearing pass over all 4096 lines (one line per cycle, all levels at once)
// runs before the first access is taken
module multilevel_direct_mapped_cache_tags (
  input  logic                             clk,
  input  logic                             rst_n,
  mdmc_in_if.sink                          in_if,
  mdmc_out_if.source                       out_if,
  input  logic                             cfg_we,
  input  logic [mdmc_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [mdmc_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import mdmc_pkg::*;

  // configuration
  logic [1:0] cfg_filter_r;
  logic [1:0] cfg_levels_r;
  logic [2:0] cfg_offset_r;
  logic [CFG_DATA_W-1:0] cfg_iw_r [NUM_LEVELS];

  // clearing pass
  idx_t clr_idx_r;
  logic clr_done_r;

  // compare stage
  logic       lk_v_r;
  logic       lk_skip_r;
  logic       lk_wr_r;
  logic [1:0] lk_cnt_r;
  split_t     lk_split_r [NUM_LEVELS];

  // output register
  logic       out_valid_r;
  logic       out_ignored_r;
  logic [1:0] out_hit_r;
  logic [2:0] out_evict_r;
  logic       out_wr_r;

  logic       accept;
  logic       look_go;
  logic       skip;
  logic [2:0] off_eff;
  logic [1:0] cnt_eff;
  split_t     in_split [NUM_LEVELS];
  lvl_ctl_t   ctl [NUM_LEVELS];
  lvl_sts_t   sts [NUM_LEVELS];
  idx_t       wr_idx [NUM_LEVELS];
  logic [NUM_LEVELS-1:0] reach;
  logic [NUM_LEVELS-1:0] evict;
  logic [1:0] hit_level;

  assign in_if.ready = clr_done_r && !lk_v_r;
  assign accept      = in_if.valid && in_if.ready;
  assign look_go     = lk_v_r && (!out_valid_r || out_if.ready);

  always_comb begin
    if (cfg_offset_r < 3'd2) begin
      off_eff = 3'd2;
    end else if (cfg_offset_r > 3'd6) begin
      off_eff = 3'd6;
    end else begin
      off_eff = cfg_offset_r;
    end
  end

  assign cnt_eff = (cfg_levels_r == 2'd0) ? 2'd1 : cfg_levels_r;
  // filter code three acts as unified
  assign skip = ((cfg_filter_r == FILT_INSTR) && in_if.is_data) ||
                ((cfg_filter_r == FILT_DATA) && !in_if.is_data);

  assign reach[0] = !lk_skip_r;
  assign reach[1] = reach[0] && !sts[0].hit && (lk_cnt_r >= 2'd2);
  assign reach[2] = reach[1] && !sts[1].hit && (lk_cnt_r == 2'd3);

  for (genvar l = 0; l < NUM_LEVELS; l++) begin : g_level
    assign in_split[l]    = split_addr(in_if.address, off_eff, clamp_iw(cfg_iw_r[l]));
    assign ctl[l].rd_en   = accept;
    assign ctl[l].upd_en  = look_go && reach[l];
    assign ctl[l].clr_en  = !clr_done_r;
    assign ctl[l].is_write = lk_wr_r;
    assign wr_idx[l]      = clr_done_r ? lk_split_r[l].idx : clr_idx_r;
    assign evict[l]       = reach[l] && sts[l].victim_dirty;

    mdmc_level u_level (
      .clk     (clk),
      .ctl     (ctl[l]),
      .rd_idx  (in_split[l].idx),
      .wr_idx  (wr_idx[l]),
      .cmp_tag (lk_split_r[l].tag),
      .sts     (sts[l])
    );
  end

  always_comb begin
    priority if (reach[0] && sts[0].hit) begin
      hit_level = 2'd1;
    end else if (reach[1] && sts[1].hit) begin
      hit_level = 2'd2;
    end else if (reach[2] && sts[2].hit) begin
      hit_level = 2'd3;
    end else begin
      hit_level = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_filter_r <= FILT_UNIFIED;
      cfg_levels_r <= 2'd1;
      cfg_offset_r <= 3'd2;
      cfg_iw_r[0]  <= 4'd8;
      cfg_iw_r[1]  <= 4'd10;
      cfg_iw_r[2]  <= 4'd12;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FILTER: cfg_filter_r <= cfg_data[1:0];
        REG_LEVELS: cfg_levels_r <= cfg_data[1:0];
        REG_OFFSET: cfg_offset_r <= cfg_data[2:0];
        REG_L1_IW:  cfg_iw_r[0]  <= cfg_data;
        REG_L2_IW:  cfg_iw_r[1]  <= cfg_data;
        REG_L3_IW:  cfg_iw_r[2]  <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_idx_r  <= '0;
      clr_done_r <= 1'b0;
    end else if (!clr_done_r) begin
      clr_idx_r <= clr_idx_r + 1'b1;
      if (&clr_idx_r) begin
        clr_done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lk_v_r <= 1'b0;
    end else if (accept) begin
      lk_v_r <= 1'b1;
    end else if (look_go) begin
      lk_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      lk_skip_r <= skip;
      lk_wr_r   <= in_if.op;
      lk_cnt_r  <= cnt_eff;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        lk_split_r[l] <= in_split[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (look_go) begin
      out_valid_r <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (look_go) begin
      out_ignored_r <= lk_skip_r;
      out_hit_r     <= hit_level;
      out_evict_r   <= evict;
      out_wr_r      <= lk_wr_r;
    end
  end

  assign out_if.valid            = out_valid_r;
  assign out_if.ignored          = out_ignored_r;
  assign out_if.hit_level        = out_hit_r;
  assign out_if.dirty_evict_mask = out_evict_r;
  assign out_if.was_write        = out_wr_r;

  a_no_update_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    !clr_done_r |-> !look_go)
    else $error("line update during clearing pass");

  a_accept_fills_stage: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> lk_v_r)
    else $error("accepted access did not reach compare stage");

  a_ignored_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_ignored_r |-> (out_hit_r == 2'd0) && (out_evict_r == 3'd0))
    else $error("ignored access reported a hit or eviction");

  a_evict_below_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (out_hit_r != 2'd0) |-> ((out_evict_r >> (out_hit_r - 2'd1)) == 3'd0))
    else $error("eviction reported at or beyond the hit level");

endmodule

// ===== sim/lookup_tracker_pkg.sv =====
package lookup_tracker_pkg;
  import mdmc_pkg::*;

  // filter code with no name in the block's package, handled as unified
  localparam logic [1:0] FILT_SPARE = 2'd3;

  typedef struct packed {
    logic       ignored;
    logic [1:0] hit_level;
    logic [2:0] dirty_evict_mask;
    logic       was_write;
  } lookup_t;

  class lookup_tracker;
    logic [1:0]            filter;
    logic [1:0]            levels;
    logic [2:0]            offset;
    logic [CFG_DATA_W-1:0] index_bits [NUM_LEVELS];
    bit                    line_valid [NUM_LEVELS][LINE_COUNT];
    bit                    line_dirty [NUM_LEVELS][LINE_COUNT];
    addr_t                 line_tag   [NUM_LEVELS][LINE_COUNT];
    lookup_t               lookups_due[$];
    int                    errors;
    int                    results_checked;
    int                    ignored_seen;
    int                    hits [4];
    int                    dirty_evictions;

    function new();
      filter        = FILT_UNIFIED;
      levels        = 2'd1;
      offset        = 3'd2;
      index_bits[0] = 4'd8;
      index_bits[1] = 4'd10;
      index_bits[2] = 4'd12;
      for (int l = 0; l < NUM_LEVELS; l++) begin
        for (int i = 0; i < LINE_COUNT; i++) begin
          line_valid[l][i] = 1'b0;
          line_dirty[l][i] = 1'b0;
          line_tag[l][i]   = '0;
        end
      end
      errors          = 0;
      results_checked = 0;
      ignored_seen    = 0;
      dirty_evictions = 0;
      for (int h = 0; h < 4; h++) hits[h] = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_FILTER: filter = val[1:0];
        REG_LEVELS: levels = val[1:0];
        REG_OFFSET: offset = val[2:0];
        REG_L1_IW:  index_bits[0] = val;
        REG_L2_IW:  index_bits[1] = val;
        REG_L3_IW:  index_bits[2] = val;
        default: ;
      endcase
    endfunction

    // walk the levels in order; every level missed on the way takes the new tag
    function void note_access(logic op, logic is_data, addr_t addr);
      lookup_t res;
      int      depth;
      int      off;
      int      iw;
      int      lvl;
      addr_t   idx;
      addr_t   tag;
      res           = '0;
      res.was_write = op;
      res.ignored   = (filter == FILT_INSTR && is_data) || (filter == FILT_DATA && !is_data);
      if (!res.ignored) begin
        depth = (levels == 2'd0) ? 1 : int'(levels);
        off   = int'(offset);
        off   = (off < 2) ? 2 : (off > 6) ? 6 : off;
        lvl   = 0;
        while (lvl < depth && res.hit_level == 2'd0) begin
          iw  = (int'(index_bits[lvl]) > LEVEL_INDEX_BITS) ? LEVEL_INDEX_BITS
                                                            : int'(index_bits[lvl]);
          idx = (addr >> off) & ((addr_t'(1) << iw) - addr_t'(1));
          tag = addr >> (off + iw);
          if (line_valid[lvl][idx] && line_tag[lvl][idx] == tag) begin
            if (op) line_dirty[lvl][idx] = 1'b1;
            res.hit_level = 2'(lvl + 1);
          end else begin
            if (line_valid[lvl][idx] && line_dirty[lvl][idx]) res.dirty_evict_mask[lvl] = 1'b1;
            line_tag[lvl][idx]   = tag;
            line_valid[lvl][idx] = 1'b1;
            line_dirty[lvl][idx] = op;
          end
          lvl++;
        end
      end
      lookups_due.push_back(res);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_lookup(lookup_t got);
      lookup_t want;
      results_checked++;
      if (lookups_due.size() == 0) begin
        report($sformatf("result %0d arrived with no access pending", results_checked));
        return;
      end
      want = lookups_due.pop_front();
      if (got.ignored !== want.ignored)
        report($sformatf("result %0d ignored %b, expected %b",
                         results_checked, got.ignored, want.ignored));
      if (got.hit_level !== want.hit_level)
        report($sformatf("result %0d hit_level %0d, expected %0d",
                         results_checked, got.hit_level, want.hit_level));
      if (got.dirty_evict_mask !== want.dirty_evict_mask)
        report($sformatf("result %0d dirty_evict_mask %b, expected %b",
                         results_checked, got.dirty_evict_mask, want.dirty_evict_mask));
      if (got.was_write !== want.was_write)
        report($sformatf("result %0d was_write %b, expected %b",
                         results_checked, got.was_write, want.was_write));
      if (want.ignored) begin
        ignored_seen++;
      end else begin
        hits[want.hit_level]++;
        dirty_evictions += $countones(want.dirty_evict_mask);
      end
    endtask
  endclass

endpackage

// ===== sim/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mdmc_pkg::*;
  import lookup_tracker_pkg::*;

  localparam int RANDOM_PHASES   = 8;
  localparam int ITEMS_PER_PHASE = 75;
  localparam int LONG_HOLD       = 300;
  localparam int HOT_COUNT       = 8;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mdmc_in_if  in_if ();
  mdmc_out_if out_if ();

  multilevel_direct_mapped_cache_tags dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_if     (in_if),
    .out_if    (out_if),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  lookup_tracker tracker = new();
  bit            send_steady;
  bit            recv_steady;
  int            long_hold;
  int            settings_used;
  addr_t         hot_lines [HOT_COUNT];

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // the clearing pass and all phases of traffic fit well inside this
  initial begin
    #5_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  task automatic put_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  task automatic write_config(logic [1:0] filter, logic [1:0] levels, logic [2:0] offset,
                              logic [3:0] iw1, logic [3:0] iw2, logic [3:0] iw3);
    put_reg(REG_FILTER, CFG_DATA_W'(filter));
    put_reg(REG_LEVELS, CFG_DATA_W'(levels));
    put_reg(REG_OFFSET, CFG_DATA_W'(offset));
    put_reg(REG_L1_IW, iw1);
    put_reg(REG_L2_IW, iw2);
    put_reg(REG_L3_IW, iw3);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // valid stays high after acceptance so a zero gap gives back-to-back words
  task automatic send_access(logic op, logic is_data, addr_t addr);
    int gap;
    gap = send_steady ? 0 : $urandom_range(0, 15);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid   <= 1'b1;
    in_if.op      <= op;
    in_if.is_data <= is_data;
    in_if.address <= addr;
    do @(posedge clk); while (in_if.ready !== 1'b1);
    tracker.note_access(op, is_data, addr);
  endtask

  task automatic end_phase();
    in_if.valid <= 1'b0;
    while (tracker.lookups_due.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // small working set sharing low bits so lines collide and come back
  function automatic void refill_hot_lines();
    addr_t shared;
    shared = $urandom();
    for (int k = 0; k < HOT_COUNT; k++) begin
      hot_lines[k] = shared ^ (addr_t'($urandom_range(0, 7)) << 20)
                            ^ (addr_t'($urandom_range(0, 3)) << 8);
    end
  endfunction

  function automatic addr_t pick_address();
    addr_t a;
    if ($urandom_range(0, 9) < 7) begin
      a = hot_lines[$urandom_range(0, HOT_COUNT - 1)] ^ addr_t'($urandom_range(0, 63));
    end else begin
      a = $urandom();
    end
    return a;
  endfunction

  initial begin : result_sink
    int      stall;
    lookup_t got;
    out_if.ready = 1'b0;
    forever begin
      if (long_hold > 0) begin
        stall     = long_hold;
        long_hold = 0;
      end else begin
        stall = recv_steady ? 0 : $urandom_range(0, 15);
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk); while (out_if.valid !== 1'b1);
      got.ignored          = out_if.ignored;
      got.hit_level        = out_if.hit_level;
      got.dirty_evict_mask = out_if.dirty_evict_mask;
      got.was_write        = out_if.was_write;
      tracker.check_lookup(got);
    end
  end

  initial begin : stimulus
    logic [1:0] filter;
    rst_n         = 1'b0;
    cfg_we        = 1'b0;
    cfg_index     = '0;
    cfg_data      = '0;
    in_if.valid   = 1'b0;
    in_if.op      = 1'b0;
    in_if.is_data = 1'b0;
    in_if.address = '0;
    send_steady   = 1'b0;
    recv_steady   = 1'b0;
    long_hold     = 0;
    settings_used = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // three small levels: cold miss, hits, dirty eviction, fallback hit in level 2
    write_config(FILT_UNIFIED, 2'd3, 3'd2, 4'd2, 4'd3, 4'd4);
    send_access(1'b0, 1'b0, 32'h0000_0000);
    send_access(1'b0, 1'b0, 32'h0000_0000);
    send_access(1'b1, 1'b1, 32'h0000_0003);
    send_access(1'b1, 1'b1, 32'h0000_0010);
    send_access(1'b0, 1'b1, 32'h0000_0000);
    send_access(1'b1, 1'b1, 32'hFFFF_FFFF);
    send_access(1'b0, 1'b0, 32'hFFFF_FFFC);
    send_access(1'b1, 1'b1, 32'h8000_0000);
    send_access(1'b0, 1'b1, 32'h7FFF_FFFF);
    end_phase();

    // spare filter code, zero levels, offset above range, oversized index widths
    write_config(FILT_SPARE, 2'd0, 3'd7, 4'd15, 4'd0, 4'd13);
    send_access(1'b1, 1'b1, 32'h1234_5678);
    send_access(1'b0, 1'b0, 32'h1234_5640);
    send_access(1'b1, 1'b0, 32'hABCD_EF00);
    send_access(1'b0, 1'b1, 32'h5555_5555);
    end_phase();

    // instruction-only filter, offset below range, zero-width first level
    write_config(FILT_INSTR, 2'd2, 3'd0, 4'd0, 4'd12, 4'd1);
    send_access(1'b0, 1'b1, 32'h0000_0001);
    send_access(1'b1, 1'b0, 32'h0000_0100);
    send_access(1'b1, 1'b1, 32'h0000_0100);
    send_access(1'b0, 1'b0, 32'h0000_0104);
    end_phase();

    write_config(FILT_DATA, 2'd3, 3'd6, 4'd12, 4'd12, 4'd12);
    send_access(1'b0, 1'b0, 32'hDEAD_BEEF);
    send_access(1'b1, 1'b1, 32'hDEAD_BEEF);
    send_access(1'b0, 1'b1, 32'hDEAD_BEC0);
    send_access(1'b1, 1'b0, 32'h0000_0000);
    end_phase();

    // lines are kept across settings, so old tags meet new address splits
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      filter = ($urandom_range(0, 2) == 0) ? 2'($urandom_range(0, 3)) : FILT_UNIFIED;
      case (phase)
        0: write_config(filter, 2'd3, 3'd7, 4'd15, 4'd15, 4'd15);
        1: write_config(filter, 2'd0, 3'd0, 4'd0, 4'd0, 4'd0);
        default: write_config(filter, 2'($urandom_range(0, 3)), 3'($urandom_range(0, 7)),
                              4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                              4'($urandom_range(0, 15)));
      endcase
      refill_hot_lines();
      send_steady = ($urandom_range(0, 3) == 0);
      recv_steady = ($urandom_range(0, 3) == 0);
      if (phase == 3) begin
        send_steady = 1'b1;
        long_hold   = LONG_HOLD;
      end
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_access(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_address());
      end
      end_phase();
    end

    $display("run covered %0d accesses under %0d register settings, %0d filtered out",
             tracker.results_checked, settings_used, tracker.ignored_seen);
    $display("hits in level 1/2/3: %0d/%0d/%0d, missed all levels: %0d, dirty evictions: %0d",
             tracker.hits[1], tracker.hits[2], tracker.hits[3], tracker.hits[0],
             tracker.dirty_evictions);
    if (tracker.errors == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule
